// ===== hdl/ipid_pkg.sv =====
// ----------------------------------------------------------------------------
// ipid_pkg
// Types, widths and a helper function shared by the incremental PID position
// loop modules.
// ----------------------------------------------------------------------------
package ipid_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int GAIN_BITS      = 18;
   localparam int ACC_BITS       = 40;
   localparam int LIMIT_BITS     = 38;
   localparam int DUTY_BITS      = 16;
   localparam int ERR_BITS       = ANGLE_BITS + 1;
   localparam int PROD_BITS      = ERR_BITS + GAIN_BITS;
   localparam int SAT_BITS       = ((PROD_BITS > ACC_BITS) ? PROD_BITS : ACC_BITS) + 1;
   localparam int CMP_BITS       = ((ACC_BITS > LIMIT_BITS) ? ACC_BITS : LIMIT_BITS) + 2;
   localparam int REM_BITS       = LIMIT_BITS + 1;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (GAIN_BITS > LIMIT_BITS) ? GAIN_BITS : LIMIT_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DUTY_BITS);
   localparam int TERM_BITS      = 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(8388608);
   localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DUTY_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic signed [DUTY_BITS-1:0] DUTY_MAX = {1'b0, {(DUTY_BITS-1){1'b1}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN_K1     = 2'd0,
      CSR_GAIN_K2     = 2'd1,
      CSR_GAIN_K3     = 2'd2,
      CSR_DRIVE_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic [TERM_BITS-1:0] {
      TERM_CUR   = 2'd0,
      TERM_PREV1 = 2'd1,
      TERM_PREV2 = 2'd2
   } term_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_ADD_PREV,
      ST_CLAMP,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     load;
      logic     mul;
      term_type term;
      logic     add;
      logic     add_prev;
      logic     clamp;
      logic     div_step;
      logic     out_load;
   } cmd_type;

   function automatic logic signed [ACC_BITS-1:0] sat_acc(
      input logic signed [SAT_BITS-1:0] v
   );
      logic signed [ACC_BITS-1:0] r;
      if (v > SAT_BITS'(ACC_MAX)) begin
         r = ACC_MAX;
      end else if (v < SAT_BITS'(ACC_MIN)) begin
         r = ACC_MIN;
      end else begin
         r = v[ACC_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ipid_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipid_ctrl
// Sequencer for one control tick: three multiply and accumulate rounds, the
// previous drive, the clamp, the duty division and the result register.
// ----------------------------------------------------------------------------
module ipid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ipid_pkg::cmd_type cmd
);

   ipid_pkg::state_type state_ff, state_in;
   ipid_pkg::term_type  term_ff, term_in;
   logic [ipid_pkg::DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ipid_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipid_pkg::ST_IDLE: begin
            if (req_valid) state_in = ipid_pkg::ST_MUL;
         end
         ipid_pkg::ST_MUL: begin
            state_in = ipid_pkg::ST_ADD;
         end
         ipid_pkg::ST_ADD: begin
            if (term_ff == ipid_pkg::TERM_PREV2) state_in = ipid_pkg::ST_ADD_PREV;
            else state_in = ipid_pkg::ST_MUL;
         end
         ipid_pkg::ST_ADD_PREV: begin
            state_in = ipid_pkg::ST_CLAMP;
         end
         ipid_pkg::ST_CLAMP: begin
            state_in = ipid_pkg::ST_DIV;
         end
         ipid_pkg::ST_DIV: begin
            if (div_cnt_ff == ipid_pkg::DIV_LAST) state_in = ipid_pkg::ST_OUT;
         end
         ipid_pkg::ST_OUT: begin
            if (out_free) state_in = ipid_pkg::ST_IDLE;
         end
         default: begin
            state_in = ipid_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.term     = term_ff;
      term_in      = term_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ipid_pkg::ST_IDLE: begin
            cmd.load = req_valid;
            term_in  = ipid_pkg::TERM_CUR;
         end
         ipid_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ipid_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            case (term_ff)
               ipid_pkg::TERM_CUR:   term_in = ipid_pkg::TERM_PREV1;
               ipid_pkg::TERM_PREV1: term_in = ipid_pkg::TERM_PREV2;
               default:              term_in = ipid_pkg::TERM_CUR;
            endcase
         end
         ipid_pkg::ST_ADD_PREV: begin
            cmd.add_prev = 1'b1;
         end
         ipid_pkg::ST_CLAMP: begin
            cmd.clamp  = 1'b1;
            div_cnt_in = '0;
         end
         ipid_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
         end
         ipid_pkg::ST_OUT: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipid_pkg::ST_IDLE;
         term_ff      <= ipid_pkg::TERM_CUR;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/ipid_datapath.sv =====
// ----------------------------------------------------------------------------
// ipid_datapath
// Gain and limit registers, loop history, shared multiplier, saturating
// accumulator, clamp and a restoring divider for the normalized duty.
// ----------------------------------------------------------------------------
module ipid_datapath (
   input  logic                                      clock,
   input  logic                                      reset,
   input  ipid_pkg::cmd_type                         cmd,
   input  logic                                      req_mode,
   input  logic signed [ipid_pkg::ANGLE_BITS-1:0]    req_target_angle,
   input  logic signed [ipid_pkg::ANGLE_BITS-1:0]    req_measured_angle,
   input  logic                                      csr_valid,
   input  logic [ipid_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ipid_pkg::CSR_DATA_BITS-1:0]        csr_data,
   output logic signed [ipid_pkg::DUTY_BITS-1:0]     rsp_pwm_duty,
   output logic                                      rsp_clamped
);

   logic signed [ipid_pkg::GAIN_BITS-1:0]  gain_k1_ff, gain_k2_ff, gain_k3_ff;
   logic [ipid_pkg::LIMIT_BITS-1:0]        limit_ff;
   logic signed [ipid_pkg::ERR_BITS-1:0]   err_ff, err_prev1_ff, err_prev2_ff;
   logic signed [ipid_pkg::ACC_BITS-1:0]   drive_prev_ff, acc_ff;
   logic signed [ipid_pkg::PROD_BITS-1:0]  prod_ff;
   logic [ipid_pkg::REM_BITS-1:0]          rem_ff;
   logic [ipid_pkg::LIMIT_BITS-1:0]        div_ff;
   logic [ipid_pkg::DUTY_BITS-1:0]         quo_ff;
   logic                                   neg_ff, clip_ff;
   logic signed [ipid_pkg::DUTY_BITS-1:0]  duty_ff;
   logic                                   clamped_ff;

   logic signed [ipid_pkg::ERR_BITS-1:0]   mul_a;
   logic signed [ipid_pkg::GAIN_BITS-1:0]  mul_b;
   logic signed [ipid_pkg::PROD_BITS-1:0]  mul_p;
   logic signed [ipid_pkg::ACC_BITS-1:0]   prod_sat;
   logic [ipid_pkg::LIMIT_BITS-1:0]        lim_eff;
   logic signed [ipid_pkg::CMP_BITS-1:0]   u_wide, lim_wide, u_abs;
   logic                                   clip_hi, clip_lo;
   logic [ipid_pkg::LIMIT_BITS-1:0]        mag;
   logic                                   div_bit;
   logic [ipid_pkg::REM_BITS-1:0]          rem_sub;
   logic signed [ipid_pkg::DUTY_BITS-1:0]  duty_val;

   always_comb begin
      case (cmd.term)
         ipid_pkg::TERM_CUR: begin
            mul_a = err_ff;
            mul_b = gain_k1_ff;
         end
         ipid_pkg::TERM_PREV1: begin
            mul_a = err_prev1_ff;
            mul_b = gain_k2_ff;
         end
         default: begin
            mul_a = err_prev2_ff;
            mul_b = gain_k3_ff;
         end
      endcase
      mul_p    = ipid_pkg::PROD_BITS'(mul_a) * ipid_pkg::PROD_BITS'(mul_b);
      prod_sat = ipid_pkg::sat_acc(ipid_pkg::SAT_BITS'(prod_ff));
   end

   always_comb begin
      lim_eff  = (limit_ff == '0) ? ipid_pkg::LIMIT_BITS'(1) : limit_ff;
      u_wide   = ipid_pkg::CMP_BITS'(acc_ff);
      lim_wide = $signed({{(ipid_pkg::CMP_BITS-ipid_pkg::LIMIT_BITS){1'b0}}, lim_eff});
      clip_hi  = u_wide > lim_wide;
      clip_lo  = u_wide < -lim_wide;
      u_abs    = u_wide[ipid_pkg::CMP_BITS-1] ? -u_wide : u_wide;
      mag      = (clip_hi || clip_lo) ? lim_eff : u_abs[ipid_pkg::LIMIT_BITS-1:0];
   end

   always_comb begin
      div_bit  = rem_ff >= ipid_pkg::REM_BITS'(div_ff);
      rem_sub  = div_bit ? (rem_ff - ipid_pkg::REM_BITS'(div_ff)) : rem_ff;
      if (neg_ff) begin
         duty_val = -$signed(quo_ff);
      end else if (quo_ff[ipid_pkg::DUTY_BITS-1]) begin
         duty_val = ipid_pkg::DUTY_MAX;
      end else begin
         duty_val = $signed(quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_k1_ff <= '0;
         gain_k2_ff <= '0;
         gain_k3_ff <= '0;
         limit_ff   <= ipid_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (ipid_pkg::csr_index_type'(csr_index))
            ipid_pkg::CSR_GAIN_K1: gain_k1_ff <= csr_data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_GAIN_K2: gain_k2_ff <= csr_data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_GAIN_K3: gain_k3_ff <= csr_data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_DRIVE_LIMIT: limit_ff <= csr_data[ipid_pkg::LIMIT_BITS-1:0];
            default: limit_ff <= limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_prev1_ff  <= '0;
         err_prev2_ff  <= '0;
         drive_prev_ff <= '0;
      end else if (cmd.load && req_mode) begin
         err_prev1_ff  <= '0;
         err_prev2_ff  <= '0;
         drive_prev_ff <= '0;
      end else if (cmd.clamp) begin
         err_prev1_ff  <= err_ff;
         err_prev2_ff  <= err_prev1_ff;
         drive_prev_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff <= ipid_pkg::ERR_BITS'(req_target_angle) -
                   ipid_pkg::ERR_BITS'(req_measured_angle);
         acc_ff <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= mul_p;
      end
      if (cmd.add) begin
         acc_ff <= ipid_pkg::sat_acc(ipid_pkg::SAT_BITS'(acc_ff) +
                                     ipid_pkg::SAT_BITS'(prod_sat));
      end
      if (cmd.add_prev) begin
         acc_ff <= ipid_pkg::sat_acc(ipid_pkg::SAT_BITS'(acc_ff) +
                                     ipid_pkg::SAT_BITS'(drive_prev_ff));
      end
      if (cmd.clamp) begin
         rem_ff  <= ipid_pkg::REM_BITS'(mag);
         div_ff  <= lim_eff;
         quo_ff  <= '0;
         neg_ff  <= acc_ff[ipid_pkg::ACC_BITS-1];
         clip_ff <= clip_hi || clip_lo;
      end
      if (cmd.div_step) begin
         rem_ff <= {rem_sub[ipid_pkg::REM_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[ipid_pkg::DUTY_BITS-2:0], div_bit};
      end
      if (cmd.out_load) begin
         duty_ff    <= duty_val;
         clamped_ff <= clip_ff;
      end
   end

   assign rsp_pwm_duty = duty_ff;
   assign rsp_clamped  = clamped_ff;

endmodule

// ===== hdl/incremental_pid_position_loop.sv =====
// ----------------------------------------------------------------------------
// incremental_pid_position_loop
// Velocity-form PID position loop producing a normalized, clamped drive duty.
// ----------------------------------------------------------------------------
// Each req beat is one control tick carrying target and measured angles and a
// mode bit; mode one clears the error and drive history before the tick.
// Each tick yields exactly one rsp beat with the Q1.15 duty and a clamp flag.
// Gains and the drive limit are written over the csr channel, which is always
// ready; writes are meant to happen only while no tick is in flight.
// One shared multiplier serves the three error terms, each in a multiply and
// an add step; the previous drive and the clamp follow, and a restoring divider
// yields one duty bit per cycle. A new req beat is taken only once the sequencer
// is back in idle, after the previous result has entered the output register.
// The result sits in an output register, so the last beat may wait for the
// receiver while the block is ready again; a further finished tick waits in
// the last step until that register is free.
// Synchronous reset returns the sequencer to idle, clears the history and
// gains, and sets the drive limit to 1.0 in accumulator units.
// ----------------------------------------------------------------------------
module incremental_pid_position_loop (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_mode,
   input  logic signed [ipid_pkg::ANGLE_BITS-1:0]    req_target_angle,
   input  logic signed [ipid_pkg::ANGLE_BITS-1:0]    req_measured_angle,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [ipid_pkg::DUTY_BITS-1:0]     rsp_pwm_duty,
   output logic                                      rsp_clamped,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ipid_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [ipid_pkg::CSR_DATA_BITS-1:0]        csr_data
);

   ipid_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   ipid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ipid_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_target_angle   (req_target_angle),
      .req_measured_angle (req_measured_angle),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_clamped        (rsp_clamped)
   );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for incremental_pid_position_loop
// Feeds control ticks with changing gains and drive limits through the block,
// predicts each duty and clamp flag with its own fixed-point loop model, and
// compares every result beat while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_TICKS = 150;

   typedef struct packed {
      logic                                   mode;
      logic signed [ipid_pkg::ANGLE_BITS-1:0] target;
      logic signed [ipid_pkg::ANGLE_BITS-1:0] measured;
   } tick_item_type;

   typedef struct packed {
      logic signed [ipid_pkg::DUTY_BITS-1:0] duty;
      logic                                  clamped;
   } drive_result_type;

   class pid_scoreboard;
      logic signed [ipid_pkg::GAIN_BITS-1:0] gain_cur, gain_prev1, gain_prev2;
      logic [ipid_pkg::LIMIT_BITS-1:0]       limit;
      longint                                err1, err2, drive_acc;
      drive_result_type                      drive_q[$];
      int                                    errors, checked, clamps, saturations, ticks;

      function new();
         gain_cur = '0;
         gain_prev1 = '0;
         gain_prev2 = '0;
         limit = ipid_pkg::LIMIT_RESET;
         err1 = 0;
         err2 = 0;
         drive_acc = 0;
         errors = 0;
         checked = 0;
         clamps = 0;
         saturations = 0;
         ticks = 0;
      endfunction

      function void set_reg(ipid_pkg::csr_index_type idx,
                            logic [ipid_pkg::CSR_DATA_BITS-1:0] data);
         case (idx)
            ipid_pkg::CSR_GAIN_K1:     gain_cur = data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_GAIN_K2:     gain_prev1 = data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_GAIN_K3:     gain_prev2 = data[ipid_pkg::GAIN_BITS-1:0];
            ipid_pkg::CSR_DRIVE_LIMIT: limit = data[ipid_pkg::LIMIT_BITS-1:0];
            default:                   ;
         endcase
      endfunction

      function longint clip_acc(longint v);
         longint hi, lo;
         hi = longint'(ipid_pkg::ACC_MAX);
         lo = longint'(ipid_pkg::ACC_MIN);
         if (v > hi) begin
            saturations++;
            return hi;
         end
         if (v < lo) begin
            saturations++;
            return lo;
         end
         return v;
      endfunction

      function void note_tick(tick_item_type it);
         longint           e, u, lim, u_norm, duty;
         drive_result_type r;
         ticks++;
         if (it.mode) begin
            err1 = 0;
            err2 = 0;
            drive_acc = 0;
         end
         e = longint'(it.target) - longint'(it.measured);
         u = clip_acc(e * longint'(gain_cur));
         u = clip_acc(u + clip_acc(err1 * longint'(gain_prev1)));
         u = clip_acc(u + clip_acc(err2 * longint'(gain_prev2)));
         u = clip_acc(u + drive_acc);
         lim = (limit == '0) ? 1 : longint'(limit);
         r.clamped = 1'b0;
         if (u > lim) begin
            u_norm = lim;
            r.clamped = 1'b1;
         end else if (u < -lim) begin
            u_norm = -lim;
            r.clamped = 1'b1;
         end else begin
            u_norm = u;
         end
         duty = (u_norm * 32768) / lim;
         if (duty > 32767) duty = 32767;
         if (duty < -32768) duty = -32768;
         r.duty = duty[ipid_pkg::DUTY_BITS-1:0];
         drive_acc = u;
         err2 = err1;
         err1 = e;
         if (r.clamped) clamps++;
         drive_q.push_back(r);
      endfunction

      function void check_duty(logic signed [ipid_pkg::DUTY_BITS-1:0] duty, logic clamped);
         drive_result_type want;
         if (drive_q.size() == 0) begin
            $display("%0t: result beat with no tick outstanding, duty %0d clamped %0b",
                     $time, duty, clamped);
            errors++;
            return;
         end
         want = drive_q.pop_front();
         checked++;
         if (duty !== want.duty) begin
            $display("%0t: pwm_duty mismatch, expected %0d, actual %0d",
                     $time, want.duty, duty);
            errors++;
         end
         if (clamped !== want.clamped) begin
            $display("%0t: clamped mismatch, expected %0b, actual %0b",
                     $time, want.clamped, clamped);
            errors++;
         end
      endfunction

      function int pending();
         return drive_q.size();
      endfunction
   endclass

   logic                                   clock;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic                                   req_mode = 1'b0;
   logic signed [ipid_pkg::ANGLE_BITS-1:0] req_target_angle = '0;
   logic signed [ipid_pkg::ANGLE_BITS-1:0] req_measured_angle = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [ipid_pkg::DUTY_BITS-1:0]  rsp_pwm_duty;
   logic                                   rsp_clamped;
   logic                                   csr_valid = 1'b0;
   logic                                   csr_ready;
   logic [ipid_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [ipid_pkg::CSR_DATA_BITS-1:0]     csr_data = '0;

   pid_scoreboard board;
   tick_item_type tick_q[$];
   int            burst_left = 0;
   int            quiet = 0;
   int            settings_done = 0;
   logic [15:0]   stall_pat = 16'hffff;
   logic [3:0]    stall_pos = '0;
   int            stall_win = 0;

   incremental_pid_position_loop DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_target_angle   (req_target_angle),
      .req_measured_angle (req_measured_angle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pwm_duty       (rsp_pwm_duty),
      .rsp_clamped        (rsp_clamped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= stall_pat[stall_pos];
         stall_pos <= stall_pos + 1'b1;
         if (stall_win == 0) begin
            stall_win <= $urandom_range(400, 100);
            case ($urandom_range(3, 0))
               0:       stall_pat <= 16'hffff;
               1:       stall_pat <= 16'($urandom) | 16'h0001;
               2:       stall_pat <= 16'($urandom & $urandom) | 16'h0001;
               default: stall_pat <= 16'($urandom | $urandom);
            endcase
         end else begin
            stall_win <= stall_win - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_duty(rsp_pwm_duty, rsp_clamped);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet <= 0;
         end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat on any channel for %0d cycles", $time, quiet);
            $display("incremental_pid_position_loop verification failed");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   function automatic int clip_angle(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int pick_angle();
      case ($urandom_range(7, 0))
         0:       return 32767;
         1:       return -32768;
         default: return int'($urandom_range(65535, 0)) - 32768;
      endcase
   endfunction

   function automatic logic signed [ipid_pkg::GAIN_BITS-1:0] rand_gain(int wide);
      if (wide != 0) return ipid_pkg::GAIN_BITS'($urandom);
      return ipid_pkg::GAIN_BITS'(int'($urandom_range(16384, 0)) - 8192);
   endfunction

   function automatic logic [ipid_pkg::LIMIT_BITS-1:0] rand_limit();
      case ($urandom_range(2, 0))
         0:       return ipid_pkg::LIMIT_BITS'({$urandom, $urandom});
         1:       return ipid_pkg::LIMIT_BITS'($urandom_range(1 << 24, 1));
         default: return ipid_pkg::LIMIT_BITS'($urandom_range(1 << 30, 1 << 20));
      endcase
   endfunction

   task automatic push_tick(input int mode, input int target, input int measured);
      tick_item_type it;
      it.mode = mode[0];
      it.target = target[ipid_pkg::ANGLE_BITS-1:0];
      it.measured = measured[ipid_pkg::ANGLE_BITS-1:0];
      tick_q.push_back(it);
   endtask

   task automatic build_ticks(input int count);
      int n, style, tgt, meas;
      tick_q.delete();
      while (tick_q.size() < count) begin
         if ($urandom_range(99, 0) < 15) begin
            n = $urandom_range(5, 1);
            repeat (n) push_tick($urandom_range(1, 0), $urandom, $urandom);
         end else begin
            style = $urandom_range(2, 0);
            tgt = pick_angle();
            meas = pick_angle();
            if (style == 1) begin
               n = $urandom_range(60, 10);
               meas = clip_angle(tgt + ((tgt >= 0) ? -40000 : 40000) +
                                 int'($urandom_range(2000, 0)) - 1000);
            end else begin
               n = $urandom_range(40, 3);
            end
            for (int k = 0; k < n; k++) begin
               push_tick(int'(k == 0), tgt, meas);
               case (style)
                  0: meas = clip_angle(meas + (tgt - meas) / 4 +
                                       int'($urandom_range(64, 0)) - 32);
                  1: ;
                  default: begin
                     tgt = clip_angle(tgt + int'($urandom_range(512, 0)) - 256);
                     meas = clip_angle(meas + int'($urandom_range(512, 0)) - 256);
                  end
               endcase
            end
         end
      end
   endtask

   task automatic drive_ticks();
      int gap_len;
      for (int i = 0; i < tick_q.size(); i++) begin
         req_valid <= 1'b1;
         req_mode <= tick_q[i].mode;
         req_target_angle <= tick_q[i].target;
         req_measured_angle <= tick_q[i].measured;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         board.note_tick(tick_q[i]);
         burst_left--;
         gap_len = 0;
         if (burst_left <= 0) begin
            gap_len = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20)
                                                     : $urandom_range(8, 1);
         end
         if (gap_len > 0 || i == tick_q.size() - 1) req_valid <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
   endtask

   task automatic write_setting(input logic signed [ipid_pkg::GAIN_BITS-1:0] k1, k2, k3,
                                input logic [ipid_pkg::LIMIT_BITS-1:0] lim);
      ipid_pkg::csr_index_type            order [4];
      logic [ipid_pkg::CSR_DATA_BITS-1:0] vals [4];
      order = '{ipid_pkg::CSR_GAIN_K1, ipid_pkg::CSR_GAIN_K2, ipid_pkg::CSR_GAIN_K3,
                ipid_pkg::CSR_DRIVE_LIMIT};
      vals[0] = ipid_pkg::CSR_DATA_BITS'(k1);
      vals[1] = ipid_pkg::CSR_DATA_BITS'(k2);
      vals[2] = ipid_pkg::CSR_DATA_BITS'(k3);
      vals[3] = ipid_pkg::CSR_DATA_BITS'(lim);
      for (int r = 0; r < 4; r++) begin
         csr_valid <= 1'b1;
         csr_index <= order[r];
         csr_data <= vals[r];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         board.set_reg(order[r], vals[r]);
      end
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   task automatic settle();
      while (board.pending() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      logic signed [ipid_pkg::GAIN_BITS-1:0] k1, k2, k3;
      logic [ipid_pkg::LIMIT_BITS-1:0]       lim;
      int                                    wide;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_setting(18'sd4096, -18'sd2047, 18'sd1024, ipid_pkg::LIMIT_RESET);
      tick_q.delete();
      push_tick(1, 0, 0);
      push_tick(1, 2048, 0);
      push_tick(1, -2048, 0);
      push_tick(1, 2049, 0);
      push_tick(1, 0, 1);
      push_tick(0, 0, 0);
      push_tick(0, 1234, 1234);
      repeat (3) push_tick(0, 32767, -32768);
      repeat (4) push_tick(0, -32768, 32767);
      push_tick(1, -32768, 32767);
      push_tick(0, 100, 50);
      push_tick(0, 100, 60);
      push_tick(1, 100, 70);
      push_tick(0, -1, -1);
      push_tick(0, 16384, -16384);
      drive_ticks();
      settle();

      for (int p = 0; p < PHASES; p++) begin
         wide = $urandom_range(1, 0);
         case (p)
            0: begin
               k1 = 18'sd6144; k2 = -18'sd8192; k3 = 18'sd2560;
               lim = ipid_pkg::LIMIT_RESET;
            end
            1: begin
               k1 = 18'sd131071; k2 = 18'sd131071; k3 = 18'sd131071; lim = '1;
            end
            2: begin
               k1 = -18'sd131072; k2 = -18'sd131072; k3 = -18'sd131072;
               lim = ipid_pkg::LIMIT_BITS'(1);
            end
            3: begin
               k1 = rand_gain(1); k2 = rand_gain(1); k3 = rand_gain(1); lim = '0;
            end
            4: begin
               k1 = '0; k2 = '0; k3 = '0; lim = rand_limit();
            end
            5: begin
               k1 = 18'sd131071; k2 = -18'sd131072; k3 = 18'sd131071;
               lim = ipid_pkg::LIMIT_RESET;
            end
            default: begin
               k1 = rand_gain(wide); k2 = rand_gain(wide); k3 = rand_gain(wide);
               lim = rand_limit();
            end
         endcase
         write_setting(k1, k2, k3, lim);
         build_ticks(PHASE_TICKS);
         drive_ticks();
         settle();
      end

      $display("Ran %0d ticks under %0d gain and limit settings; %0d results checked.",
               board.ticks, settings_done, board.checked);
      $display("Predicted %0d clamped drives and %0d accumulator saturations; %0d errors.",
               board.clamps, board.saturations, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("incremental_pid_position_loop verification clean");
      end else begin
         $display("incremental_pid_position_loop verification failed");
      end
      $finish;
   end

endmodule
